// File: rtl/tbw_pkg.sv
// Shared constants for the triangle barycentric weight pipeline.
// No dependencies.
package tbw_pkg;
    // Register stages in front of the divider lanes.
    localparam int FRONT_STAGES = 6;
    // Divider stages in addition to one per fraction bit: integer bit and rounding.
    localparam int DIV_EXTRA = 2;
endpackage

// File: rtl/tbw_req_if.sv
// Request channel: pixel position and three triangle vertices.
// Depends on nothing.
interface tbw_req_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic signed [COORD_BITS-1:0] vert_a_x;
    logic signed [COORD_BITS-1:0] vert_a_y;
    logic signed [COORD_BITS-1:0] vert_b_x;
    logic signed [COORD_BITS-1:0] vert_b_y;
    logic signed [COORD_BITS-1:0] vert_c_x;
    logic signed [COORD_BITS-1:0] vert_c_y;
    modport source (output valid, pixel_x, pixel_y, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
                    vert_c_x, vert_c_y, input ready);
    modport sink (input valid, pixel_x, pixel_y, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
                  vert_c_x, vert_c_y, output ready);
endinterface

// File: rtl/tbw_res_if.sv
// Result channel: three fixed point weights and the degenerate flag.
// Depends on nothing.
interface tbw_res_if #(parameter int FRAC_BITS = 16);
    logic                 valid;
    logic                 ready;
    logic [FRAC_BITS:0]   weight_a;
    logic [FRAC_BITS:0]   weight_b;
    logic [FRAC_BITS:0]   weight_c;
    logic                 degenerate;
    modport source (output valid, weight_a, weight_b, weight_c, degenerate, input ready);
    modport sink (input valid, weight_a, weight_b, weight_c, degenerate, output ready);
endinterface

// File: rtl/tbw_front.sv
// Front pipeline: edge vectors, cross product, sign fix, clamp and sum.
// Depends on tbw_pkg (stage count documented there).
module tbw_front import tbw_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [COORD_BITS-1:0]        i_px,
    input  logic signed [COORD_BITS-1:0]        i_py,
    input  logic signed [COORD_BITS-1:0]        i_ax,
    input  logic signed [COORD_BITS-1:0]        i_ay,
    input  logic signed [COORD_BITS-1:0]        i_bx,
    input  logic signed [COORD_BITS-1:0]        i_by,
    input  logic signed [COORD_BITS-1:0]        i_cx,
    input  logic signed [COORD_BITS-1:0]        i_cy,
    output logic [2*COORD_BITS+2:0]             o_na,
    output logic [2*COORD_BITS+2:0]             o_nb,
    output logic [2*COORD_BITS+2:0]             o_nc,
    output logic [2*COORD_BITS+4:0]             o_sum,
    output logic                                o_degen
);
    localparam int D  = COORD_BITS + 1;
    localparam int P  = 2 * D;
    localparam int A  = P + 3;
    localparam int NW = P + 1;
    localparam int SW = P + 3;

    // stage 1: edge vectors
    logic signed [D-1:0] r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z;
    // stage 2: products
    logic signed [P-1:0] r_m0, r_m1, r_m2, r_m3, r_m4, r_m5;
    // stage 3: cross product
    logic signed [P:0]   r_ux, r_uy, r_uz;
    // stage 4: sign fixed terms
    logic signed [A-1:0] r_fx, r_fy, r_fz, r_fa;
    logic                r_z4;
    // stage 5: clamped numerators
    logic [NW-1:0]       r_ca, r_cb, r_cc;
    logic                r_z5;
    // stage 6: sum
    logic [NW-1:0]       r_na, r_nb, r_nc;
    logic [SW-1:0]       r_s;
    logic                r_z6;

    logic signed [A-1:0] n_xe, n_ye, n_ze, n_fx, n_fy, n_fz;

    function automatic logic [NW-1:0] clamp(input logic signed [A-1:0] v,
                                            input logic signed [A-1:0] d);
        logic [NW-1:0] res;
        if (v < 0) res = '0;
        else if (v > d) res = d[NW-1:0];
        else res = v[NW-1:0];
        return res;
    endfunction

    always_comb begin
        n_xe = A'(r_ux);
        n_ye = A'(r_uy);
        n_ze = A'(r_uz);
        if (r_uz < 0) begin
            n_fx = -n_xe;
            n_fy = -n_ye;
            n_fz = -n_ze;
        end else begin
            n_fx = n_xe;
            n_fy = n_ye;
            n_fz = n_ze;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e1x <= D'(i_cx) - D'(i_ax);
            r_e1y <= D'(i_bx) - D'(i_ax);
            r_e1z <= D'(i_ax) - D'(i_px);
            r_e2x <= D'(i_cy) - D'(i_ay);
            r_e2y <= D'(i_by) - D'(i_ay);
            r_e2z <= D'(i_ay) - D'(i_py);

            r_m0 <= P'(r_e1y) * P'(r_e2z);
            r_m1 <= P'(r_e1z) * P'(r_e2y);
            r_m2 <= P'(r_e1z) * P'(r_e2x);
            r_m3 <= P'(r_e1x) * P'(r_e2z);
            r_m4 <= P'(r_e1x) * P'(r_e2y);
            r_m5 <= P'(r_e1y) * P'(r_e2x);

            r_ux <= (P+1)'(r_m0) - (P+1)'(r_m1);
            r_uy <= (P+1)'(r_m2) - (P+1)'(r_m3);
            r_uz <= (P+1)'(r_m4) - (P+1)'(r_m5);

            r_fx <= n_fx;
            r_fy <= n_fy;
            r_fz <= n_fz;
            r_fa <= n_fz - n_fx - n_fy;
            r_z4 <= (r_uz == '0);

            r_ca <= clamp(r_fa, r_fz);
            r_cb <= clamp(r_fy, r_fz);
            r_cc <= clamp(r_fx, r_fz);
            r_z5 <= r_z4;

            r_na <= r_ca;
            r_nb <= r_cb;
            r_nc <= r_cc;
            r_s  <= SW'(r_ca) + SW'(r_cb) + SW'(r_cc);
            r_z6 <= r_z5;
        end
    end

    assign o_na    = r_na;
    assign o_nb    = r_nb;
    assign o_nc    = r_nc;
    assign o_sum   = r_s;
    assign o_degen = r_z6;
endmodule

// File: rtl/tbw_div.sv
// One restoring divider lane, one quotient bit per stage, round to nearest at the end.
// Depends on tbw_pkg for the extra stage count.
module tbw_div import tbw_pkg::*; #(
    parameter int NUM_BITS  = 35,
    parameter int DEN_BITS  = 37,
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [NUM_BITS-1:0]  i_num,
    input  logic [DEN_BITS-1:0]  i_den,
    output logic [FRAC_BITS:0]   o_quo
);
    localparam int STEPS = FRAC_BITS + DIV_EXTRA;
    localparam int QW    = FRAC_BITS + 1;

    logic [DEN_BITS-1:0] r_rem [STEPS];
    logic [DEN_BITS-1:0] r_den [STEPS];
    logic [QW-1:0]       r_quo [STEPS];

    logic [DEN_BITS-1:0] n_num;
    assign n_num = DEN_BITS'(i_num);

    // integer bit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            if (n_num >= i_den) begin
                r_rem[0] <= n_num - i_den;
                r_quo[0] <= QW'(1);
            end else begin
                r_rem[0] <= n_num;
                r_quo[0] <= '0;
            end
        end
    end

    for (genvar k = 1; k < STEPS; k++) begin : g_step
        logic [DEN_BITS:0] n_sh;
        logic              n_ge;
        assign n_sh = {r_rem[k-1], 1'b0};
        assign n_ge = (n_sh >= {1'b0, r_den[k-1]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= r_den[k-1];
                if (k == STEPS - 1) begin
                    // round: add one when the remainder is at least half
                    r_rem[k] <= r_rem[k-1];
                    r_quo[k] <= r_quo[k-1] + QW'(n_ge);
                end else begin
                    r_rem[k] <= n_ge ? DEN_BITS'(n_sh - {1'b0, r_den[k-1]})
                                     : DEN_BITS'(n_sh);
                    r_quo[k] <= {r_quo[k-1][QW-2:0], n_ge};
                end
            end
        end
    end

    assign o_quo = r_quo[STEPS-1];
endmodule

// File: rtl/triangle_barycentric_weights.sv
// Barycentric weights of a pixel in a screen triangle, fully pipelined.
// Throughput: one request per cycle while the output register is not stalled.
// The divider lanes set the depth: one quotient bit per stage, three lanes side by side.
// The whole pipe advances when the output register is empty or taken; a stall holds it.
// Reset (i_rst_n low, synchronous) clears the valid bits only; data registers hold.
// Depends on tbw_pkg, tbw_req_if, tbw_res_if, tbw_front and tbw_div.
module triangle_barycentric_weights import tbw_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tbw_req_if.sink    i_req,
    tbw_res_if.source  o_res
);
    localparam int NW    = 2 * (COORD_BITS + 1) + 1;
    localparam int SW    = NW + 2;
    localparam int STEPS = FRAC_BITS + DIV_EXTRA;
    localparam int LAT   = FRONT_STAGES + STEPS;

    logic [LAT-1:0]   r_vld;
    logic [STEPS-1:0] r_dgn;
    logic             w_en;

    logic [NW-1:0]    w_na, w_nb, w_nc;
    logic [SW-1:0]    w_sum;
    logic             w_degen;
    logic [FRAC_BITS:0] w_qa, w_qb, w_qc;

    // advance everything when the last stage is free or being drained
    assign w_en        = !r_vld[LAT-1] || o_res.ready;
    assign i_req.ready = w_en;

    // valid bits ride alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_req.valid};
        end
    end

    // degenerate flag follows the divider stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dgn <= {r_dgn[STEPS-2:0], w_degen};
        end
    end

    tbw_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_px    (i_req.pixel_x),
        .i_py    (i_req.pixel_y),
        .i_ax    (i_req.vert_a_x),
        .i_ay    (i_req.vert_a_y),
        .i_bx    (i_req.vert_b_x),
        .i_by    (i_req.vert_b_y),
        .i_cx    (i_req.vert_c_x),
        .i_cy    (i_req.vert_c_y),
        .o_na    (w_na),
        .o_nb    (w_nb),
        .o_nc    (w_nc),
        .o_sum   (w_sum),
        .o_degen (w_degen)
    );

    // three lanes share the denominator; a zero-area triangle is masked at the end
    tbw_div #(.NUM_BITS(NW), .DEN_BITS(SW), .FRAC_BITS(FRAC_BITS)) u_div_a (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_na), .i_den (w_sum), .o_quo (w_qa)
    );
    tbw_div #(.NUM_BITS(NW), .DEN_BITS(SW), .FRAC_BITS(FRAC_BITS)) u_div_b (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_nb), .i_den (w_sum), .o_quo (w_qb)
    );
    tbw_div #(.NUM_BITS(NW), .DEN_BITS(SW), .FRAC_BITS(FRAC_BITS)) u_div_c (
        .i_clk (i_clk), .i_en (w_en), .i_num (w_nc), .i_den (w_sum), .o_quo (w_qc)
    );

    assign o_res.valid      = r_vld[LAT-1];
    assign o_res.degenerate = r_dgn[STEPS-1];
    assign o_res.weight_a   = r_dgn[STEPS-1] ? '0 : w_qa;
    assign o_res.weight_b   = r_dgn[STEPS-1] ? '0 : w_qb;
    assign o_res.weight_c   = r_dgn[STEPS-1] ? '0 : w_qc;
endmodule

// File: tb/tb_triangle_barycentric_weights.sv
// Self-checking bench for the triangle barycentric weight pipeline.
// Depends on tbw_pkg, tbw_req_if, tbw_res_if and the block triangle_barycentric_weights.
`timescale 1ns / 100ps

module tb_triangle_barycentric_weights;
    import tbw_pkg::*;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    // Pipe depth: front stages plus one divider stage per fraction bit plus the extra divider stages.
    localparam int PIPE_DEPTH = FRONT_STAGES + FRAC_BITS + DIV_EXTRA;
    localparam int RANDOM_REQS = 800;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [FRAC_BITS:0] weight_t;

    typedef struct packed {
        coord_t px, py, ax, ay, bx, by, cx, cy;
    } tri_req_t;

    typedef struct packed {
        weight_t wa, wb, wc;
        logic    degen;
    } weights_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tbw_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
    tbw_res_if #(.FRAC_BITS(FRAC_BITS))   res_ch ();

    triangle_barycentric_weights #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_res  (res_ch.source)
    );

    always #10 i_clk = ~i_clk;

    tri_req_t pending_reqs[$];
    weights_t expected_weights[$];
    int       mismatch_count = 0;
    // Set by the stimulus process to hold the sender until the pipe drains.
    bit       sender_hold = 1'b0;
    // Set to force a long receiver hold-off.
    bit       long_stall = 1'b0;
    event     long_stall_go;

    // Rounded fixed point quotient n * 2^FRAC_BITS / s, ties up.
    function automatic weight_t scaled_ratio(longint n, longint s);
        longint q;
        q = ((n << (FRAC_BITS + 1)) / s + 1) >> 1;
        return weight_t'(q);
    endfunction

    function automatic longint clamp_to(longint n, longint d);
        if (n < 0) return 0;
        if (n > d) return d;
        return n;
    endfunction

    // Compute barycentric weights exactly as the block should.
    function automatic weights_t barycentric_weights(tri_req_t r);
        longint e1x, e1y, e1z, e2x, e2y, e2z, ux, uy, uz, na, nb, nc, s;
        weights_t w;
        e1x = longint'(r.cx) - longint'(r.ax);
        e1y = longint'(r.bx) - longint'(r.ax);
        e1z = longint'(r.ax) - longint'(r.px);
        e2x = longint'(r.cy) - longint'(r.ay);
        e2y = longint'(r.by) - longint'(r.ay);
        e2z = longint'(r.ay) - longint'(r.py);
        ux = e1y * e2z - e1z * e2y;
        uy = e1z * e2x - e1x * e2z;
        uz = e1x * e2y - e1y * e2x;
        w = '0;
        if (uz == 0) begin
            w.degen = 1'b1;
            return w;
        end
        if (uz < 0) begin
            uz = -uz;
            ux = -ux;
            uy = -uy;
        end
        na = clamp_to(uz - ux - uy, uz);
        nb = clamp_to(uy, uz);
        nc = clamp_to(ux, uz);
        s = na + nb + nc;
        if (s <= 0) begin
            w.degen = 1'b1;
            return w;
        end
        w.wa = scaled_ratio(na, s);
        w.wb = scaled_ratio(nb, s);
        w.wc = scaled_ratio(nc, s);
        return w;
    endfunction

    function automatic coord_t rand_coord();
        return coord_t'($urandom);
    endfunction

    // Small coordinates around a center so most pixels land near a triangle.
    function automatic coord_t near_coord(int center, int span);
        return coord_t'(center + $signed($urandom_range(2 * span)) - span);
    endfunction

    function automatic tri_req_t make_req(int px, int py, int ax, int ay,
                                          int bx, int by, int cx, int cy);
        tri_req_t r;
        r.px = coord_t'(px); r.py = coord_t'(py);
        r.ax = coord_t'(ax); r.ay = coord_t'(ay);
        r.bx = coord_t'(bx); r.by = coord_t'(by);
        r.cx = coord_t'(cx); r.cy = coord_t'(cy);
        return r;
    endfunction

    // Driver: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_weights.push_back(barycentric_weights(pending_reqs.pop_front()));
            end
            if (req_ch.valid && !req_ch.ready) begin
                // hold the current request
            end else if (pending_reqs.size() > 0 && !sender_hold && gap_left == 0) begin
                req_ch.valid <= 1'b1;
                {req_ch.pixel_x, req_ch.pixel_y, req_ch.vert_a_x, req_ch.vert_a_y,
                 req_ch.vert_b_x, req_ch.vert_b_y, req_ch.vert_c_x, req_ch.vert_c_y}
                    <= pending_reqs[0];
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else if ($urandom_range(3) == 0) begin
                    burst_left <= $urandom_range(40);
                end else begin
                    burst_left <= $urandom_range(8);
                    gap_left <= $urandom_range(4);
                end
            end else begin
                req_ch.valid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end
        end
    end

    // Note: pending_reqs[0] stays the driven request until accepted, so the
    // pop above matches the request on the bus.

    // Long receiver hold-off, counted in cycles once the stimulus asks for it.
    always begin
        @(long_stall_go);
        long_stall = 1'b1;
        repeat (PIPE_DEPTH * 8) @(posedge i_clk);
        long_stall = 1'b0;
    end

    // Receiver stall pattern: phases of free running and of random stalls.
    int stall_phase = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (long_stall)
                res_ch.ready <= 1'b0;
            else if (stall_phase[8:7] == 2'd0)
                res_ch.ready <= 1'b1;
            else if (stall_phase[8:7] == 2'd1)
                res_ch.ready <= ($urandom_range(3) != 0);
            else
                res_ch.ready <= ($urandom_range(2) == 0);
        end
    end

    // Monitor: compare every accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        weights_t got;
        weights_t want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = '{res_ch.weight_a, res_ch.weight_b, res_ch.weight_c, res_ch.degenerate};
            if (expected_weights.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result wa=%0d wb=%0d wc=%0d degen=%0b",
                             got.wa, got.wb, got.wc, got.degen);
            end else begin
                want = expected_weights.pop_front();
                if (got != want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected wa=%0d wb=%0d wc=%0d degen=%0b,",
                                 want.wa, want.wb, want.wc, want.degen,
                                 " got wa=%0d wb=%0d wc=%0d degen=%0b",
                                 got.wa, got.wb, got.wc, got.degen);
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_weights.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int cx, cy;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: vertices, interior, outside, both windings, degenerate, extremes.
        pending_reqs.push_back(make_req(0, 0, 0, 0, 100, 0, 0, 100));
        pending_reqs.push_back(make_req(100, 0, 0, 0, 100, 0, 0, 100));
        pending_reqs.push_back(make_req(0, 100, 0, 0, 100, 0, 0, 100));
        pending_reqs.push_back(make_req(33, 33, 0, 0, 100, 0, 0, 100));
        pending_reqs.push_back(make_req(50, 50, 0, 0, 100, 0, 0, 100));
        pending_reqs.push_back(make_req(33, 33, 0, 0, 0, 100, 100, 0));
        pending_reqs.push_back(make_req(500, 500, 0, 0, 100, 0, 0, 100));
        pending_reqs.push_back(make_req(-500, -500, 0, 0, 100, 0, 0, 100));
        pending_reqs.push_back(make_req(-500, 50, 0, 0, 100, 0, 0, 100));
        pending_reqs.push_back(make_req(1, 1, 0, 0, 3, 0, 0, 3));
        pending_reqs.push_back(make_req(5, 5, 1, 1, 1, 1, 1, 1));
        pending_reqs.push_back(make_req(5, 5, 0, 0, 10, 10, 20, 20));
        pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 7, 9));
        pending_reqs.push_back(make_req(-32768, -32768, 32767, 32767, -32768, 32767,
                                        32767, -32768));
        pending_reqs.push_back(make_req(32767, 32767, -32768, -32768, 32767, -32768,
                                        -32768, 32767));
        pending_reqs.push_back(make_req(0, 0, -32768, -32768, 32767, -32768, -32768, 32767));
        pending_reqs.push_back(make_req(-1, -1, -32768, 32767, 32767, 32767, 0, -32768));
        pending_reqs.push_back(make_req(1, 2, 0, 0, 3, 0, 0, 5));
        wait_drained();

        // Random: mostly small triangles with pixels near them, some full range.
        for (int i = 0; i < RANDOM_REQS; i++) begin
            if (i == 300) begin
                // Long receiver hold-off while the sender keeps offering.
                -> long_stall_go;
            end
            if (i == 500) begin
                // Pause the sender until every outstanding result has arrived.
                sender_hold = 1'b1;
                while (expected_weights.size() > 0 || req_ch.valid) @(posedge i_clk);
                sender_hold = 1'b0;
            end
            if ($urandom_range(9) < 7) begin
                cx = $signed($urandom_range(60000)) - 30000;
                cy = $signed($urandom_range(60000)) - 30000;
                pending_reqs.push_back({near_coord(cx, 60), near_coord(cy, 60),
                                        near_coord(cx, 50), near_coord(cy, 50),
                                        near_coord(cx, 50), near_coord(cy, 50),
                                        near_coord(cx, 50), near_coord(cy, 50)});
            end else begin
                pending_reqs.push_back({rand_coord(), rand_coord(), rand_coord(),
                                        rand_coord(), rand_coord(), rand_coord(),
                                        rand_coord(), rand_coord()});
            end
            if (pending_reqs.size() > 16)
                while (pending_reqs.size() > 4) @(posedge i_clk);
        end
        wait_drained();
        repeat (PIPE_DEPTH * 2) @(posedge i_clk);
        if (mismatch_count == 0 && expected_weights.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #(20ns * 200000);
        $display("status: fail");
        $finish;
    end
endmodule
